>>> src/assert_macros.svh
// Assertion macros used by the decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle check, disabled during reset.
`define BSFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check in the cycle after the antecedent, disabled during reset.
`define BSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/bsfd_pkg.sv
// Types and constants for the byte-stuffing frame decoder.
package bsfd_pkg;

    localparam int COUNT_WIDTH_DEF = 12;
    localparam int PAYLOAD_CNT_W   = 12;
    localparam int MAX_PAYLOAD_W   = 12;
    localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RST = 12'd1000;

    localparam logic [7:0] DELIM_BYTE    = 8'h41;
    localparam logic [7:0] ESC_BYTE      = 8'h42;
    localparam logic [7:0] ESC_FOR_DELIM = 8'h43;
    localparam logic [7:0] ESC_FOR_ESC   = 8'h44;

    typedef enum logic [1:0] {
        ST_PAYLOAD  = 2'd0,
        ST_DONE     = 2'd1,
        ST_BAD_ESC  = 2'd2,
        ST_TOO_LONG = 2'd3
    } bsfd_status_t;

    typedef struct packed {
        logic in_frame;
        logic esc_pending;
    } bsfd_ctl_t;

    typedef struct packed {
        logic                     valid;
        logic [7:0]               data_byte;
        bsfd_status_t             status;
        logic [PAYLOAD_CNT_W-1:0] payload_count;
    } bsfd_res_t;

endpackage

>>> src/bsfd_step.sv
// Next-state and result logic for one received byte.
module bsfd_step
    import bsfd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic [7:0]               rx_byte,
    input  logic [MAX_PAYLOAD_W-1:0] max_payload,
    input  bsfd_ctl_t                ctl,
    input  logic [COUNT_WIDTH-1:0]   count,
    output bsfd_ctl_t                ctl_next,
    output logic [COUNT_WIDTH-1:0]   count_next,
    output bsfd_res_t                res
);

    localparam int CMP_W = (COUNT_WIDTH > MAX_PAYLOAD_W) ? COUNT_WIDTH : MAX_PAYLOAD_W;

    logic       full;
    logic       deliver;
    logic [7:0] deliver_byte;

    // Payload limit: configured maximum or counter saturation.
    assign full = (CMP_W'(count) >= CMP_W'(max_payload)) || (count == {COUNT_WIDTH{1'b1}});

    always_comb
    begin
        ctl_next     = ctl;
        count_next   = count;
        deliver      = 1'b0;
        deliver_byte = rx_byte;
        res.valid    = 1'b0;
        res.data_byte = 8'h00;
        res.status   = ST_PAYLOAD;

        if (!ctl.in_frame)
        begin
            if (rx_byte == DELIM_BYTE)
            begin
                ctl_next.in_frame    = 1'b1;
                ctl_next.esc_pending = 1'b0;
                count_next           = '0;
            end
        end
        else if (ctl.esc_pending)
        begin
            ctl_next.esc_pending = 1'b0;
            case (rx_byte)
                ESC_FOR_DELIM:
                begin
                    deliver      = 1'b1;
                    deliver_byte = DELIM_BYTE;
                end
                ESC_FOR_ESC:
                begin
                    deliver      = 1'b1;
                    deliver_byte = ESC_BYTE;
                end
                default:
                begin
                    res.valid  = 1'b1;
                    res.status = ST_BAD_ESC;
                end
            endcase
        end
        else
        begin
            case (rx_byte)
                DELIM_BYTE:
                begin
                    res.valid  = 1'b1;
                    res.status = ST_DONE;
                end
                ESC_BYTE:
                begin
                    ctl_next.esc_pending = 1'b1;
                end
                default:
                begin
                    deliver = 1'b1;
                end
            endcase
        end

        if (deliver)
        begin
            res.valid = 1'b1;
            if (full)
            begin
                res.status = ST_TOO_LONG;
            end
            else
            begin
                count_next    = count + 1'b1;
                res.data_byte = deliver_byte;
            end
        end

        // Any frame-ending result drops back to hunting.
        if (res.valid && (res.status != ST_PAYLOAD))
        begin
            ctl_next.in_frame    = 1'b0;
            ctl_next.esc_pending = 1'b0;
        end

        res.payload_count = PAYLOAD_CNT_W'(count_next);
    end

endmodule

>>> src/byte_stuffing_frame_decoder.sv
// A result appears on the master side in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the output stalls; bytes that give no result (hunting, escape) count too.
// The output register frees as it is read, so input and output stall only together.
// Reset: asynchronous, active low; hunting for the delimiter, count zero, limit 1000.
`include "assert_macros.svh"

module byte_stuffing_frame_decoder
    import bsfd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [MAX_PAYLOAD_W-1:0] cfg_wr_data,  // max_payload
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,      // [7:0] rx_byte
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [23:0]              m_tdata,      // [7:0] data_byte, [19:8] payload_count
    output logic [1:0]               m_tuser,      // [1:0] status
    output logic                     m_tlast       // frame_end
);

    logic [MAX_PAYLOAD_W-1:0] max_payload_reg;
    bsfd_ctl_t                ctl_reg;
    bsfd_ctl_t                ctl_next;
    logic [COUNT_WIDTH-1:0]   count_reg;
    logic [COUNT_WIDTH-1:0]   count_next;
    logic                     out_valid_reg;
    bsfd_res_t                res;
    bsfd_res_t                out_reg;
    logic                     accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    bsfd_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .rx_byte     (s_tdata),
        .max_payload (max_payload_reg),
        .ctl         (ctl_reg),
        .count       (count_reg),
        .ctl_next    (ctl_next),
        .count_next  (count_next),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RST;
            ctl_reg         <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_payload_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                ctl_reg       <= ctl_next;
                count_reg     <= count_next;
                out_valid_reg <= res.valid;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'h0, out_reg.payload_count, out_reg.data_byte};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = (out_reg.status != ST_PAYLOAD);

    `BSFD_ASSERT(a_esc_in_frame, !ctl_reg.esc_pending || ctl_reg.in_frame, "escape outside frame")
    `BSFD_ASSERT(a_ready_when_empty, out_valid_reg || s_tready, "input stalled with empty output")
    `BSFD_ASSERT_NEXT(a_end_hunts, accept && res.valid && (res.status != ST_PAYLOAD), !ctl_reg.in_frame, "frame end did not return to hunting")
    `BSFD_ASSERT(a_payload_count, !(m_tvalid && (m_tuser == ST_PAYLOAD)) || (m_tdata[19:8] != '0), "payload transfer with zero count")

endmodule
